### rtl/gfq_pkg.sv
// Shared types, constants and codes for the grid fault qualifier.
// No dependencies; imported by gfq_eval and grid_fault_qualifier_top.
package gfq_pkg;

   localparam int SAMPLE_BITS = 12;
   localparam int CSR_IDX_BITS = 3;
   localparam int CNT_BITS = 4;
   localparam int FQ_CNT_BITS = 3;

   localparam logic [CNT_BITS-1:0] VOLT_LIMIT_STARTUP = 4'd2;
   localparam logic [CNT_BITS-1:0] VOLT_LIMIT_RUNNING = 4'd10;
   localparam logic [CNT_BITS-1:0] FREQ_LIMIT = 4'd5;

   typedef enum logic [1:0] {
      MODE_STARTUP = 2'd0,
      MODE_RAMPUP  = 2'd1,
      MODE_RUNNING = 2'd2,
      MODE_OTHER   = 2'd3
   } mode_type;

   typedef enum logic [2:0] {
      ERR_NONE      = 3'd0,
      ERR_VOLT_LOW  = 3'd1,
      ERR_VOLT_HIGH = 3'd2,
      ERR_FREQ      = 3'd3,
      ERR_CURR_HIGH = 3'd4,
      ERR_MEASURE   = 3'd5
   } err_type;

   localparam logic [CSR_IDX_BITS-1:0] CSR_UNDERVOLT  = 3'd0;
   localparam logic [CSR_IDX_BITS-1:0] CSR_OVERVOLT   = 3'd1;
   localparam logic [CSR_IDX_BITS-1:0] CSR_FREQ_LOW   = 3'd2;
   localparam logic [CSR_IDX_BITS-1:0] CSR_FREQ_HIGH  = 3'd3;
   localparam logic [CSR_IDX_BITS-1:0] CSR_OVERCURR   = 3'd4;
   localparam logic [CSR_IDX_BITS-1:0] CSR_MEASURE    = 3'd5;

   typedef logic [SAMPLE_BITS-1:0] sample_type;

   typedef struct packed {
      mode_type   mode;
      logic       settled;
      sample_type volt_r;
      sample_type volt_y;
      sample_type volt_b;
      sample_type curr_r;
      sample_type curr_y;
      sample_type curr_b;
      sample_type grid_freq;
   } tick_type;

   typedef struct packed {
      sample_type undervolt;
      sample_type overvolt;
      sample_type freq_low;
      sample_type freq_high;
      sample_type overcurrent;
      sample_type measure;
   } limits_type;

   typedef struct packed {
      logic [CNT_BITS-1:0]    uv_cnt;
      logic [CNT_BITS-1:0]    ov_cnt;
      logic [FQ_CNT_BITS-1:0] fq_cnt;
      logic                   uv_flag;
      logic                   ov_flag;
      logic                   fq_flag;
      logic                   oc_flag;
      err_type                err;
   } qual_state_type;

endpackage

### rtl/gfq_eval.sv
// Next-state logic for one tick: threshold compares, persistence counters,
// fault flags and last error code. Depends on gfq_pkg.
module gfq_eval (
   input  gfq_pkg::tick_type       tick,
   input  gfq_pkg::limits_type     limits,
   input  gfq_pkg::qual_state_type state_cur,
   output gfq_pkg::qual_state_type state_nxt
);
   import gfq_pkg::*;

   // returns {trip, next count}
   function automatic logic [CNT_BITS:0] persist(input logic cond,
                                                 input logic [CNT_BITS-1:0] cnt,
                                                 input logic [CNT_BITS-1:0] lim);
      logic [CNT_BITS:0] inc;
      begin
         inc = {1'b0, cnt} + {{CNT_BITS{1'b0}}, 1'b1};
         if (!cond) begin
            persist = '0;
         end else if (inc >= {1'b0, lim}) begin
            persist = {1'b1, {CNT_BITS{1'b0}}};
         end else begin
            persist = {1'b0, inc[CNT_BITS-1:0]};
         end
      end
   endfunction

   logic              is_startup;
   logic              run_volt;
   logic              run_curr;
   logic [CNT_BITS-1:0] volt_lim;
   sample_type        curr_lim;
   logic              uv_cond;
   logic              ov_cond;
   logic              fq_cond;
   logic              oc_hit;
   logic [CNT_BITS:0] uv_res;
   logic [CNT_BITS:0] ov_res;
   logic [CNT_BITS:0] fq_res;

   always_comb begin
      is_startup = (tick.mode == MODE_STARTUP);
      run_volt = is_startup || (tick.mode == MODE_RUNNING && tick.settled);
      run_curr = run_volt || (tick.mode == MODE_RAMPUP && tick.settled);
      volt_lim = is_startup ? VOLT_LIMIT_STARTUP : VOLT_LIMIT_RUNNING;
      curr_lim = is_startup ? limits.measure : limits.overcurrent;

      uv_cond = tick.volt_r <= limits.undervolt || tick.volt_y <= limits.undervolt ||
                tick.volt_b <= limits.undervolt;
      ov_cond = tick.volt_r >= limits.overvolt || tick.volt_y >= limits.overvolt ||
                tick.volt_b >= limits.overvolt;
      fq_cond = tick.grid_freq <= limits.freq_low || tick.grid_freq >= limits.freq_high;
      oc_hit  = tick.curr_r >= curr_lim || tick.curr_y >= curr_lim ||
                tick.curr_b >= curr_lim;

      uv_res = persist(uv_cond, state_cur.uv_cnt, volt_lim);
      ov_res = persist(ov_cond, state_cur.ov_cnt, volt_lim);
      fq_res = persist(fq_cond, {1'b0, state_cur.fq_cnt}, FREQ_LIMIT);
   end

   always_comb begin
      state_nxt = state_cur;
      if (run_curr) begin
         state_nxt.oc_flag = oc_hit;
         if (oc_hit && !is_startup) begin
            state_nxt.err = ERR_CURR_HIGH;
         end
      end
      if (run_volt) begin
         state_nxt.uv_cnt  = uv_res[CNT_BITS-1:0];
         state_nxt.uv_flag = uv_res[CNT_BITS];
         state_nxt.ov_cnt  = ov_res[CNT_BITS-1:0];
         state_nxt.ov_flag = ov_res[CNT_BITS];
         state_nxt.fq_cnt  = fq_res[FQ_CNT_BITS-1:0];
         state_nxt.fq_flag = fq_res[CNT_BITS];
         if (uv_res[CNT_BITS]) begin
            state_nxt.err = ERR_VOLT_LOW;
         end
         if (ov_res[CNT_BITS]) begin
            state_nxt.err = ERR_VOLT_HIGH;
         end
         if (fq_res[CNT_BITS]) begin
            state_nxt.err = ERR_FREQ;
         end
      end
      if (is_startup && oc_hit) begin
         state_nxt.err = ERR_MEASURE;
      end
   end

endmodule

### rtl/grid_fault_qualifier_top.sv
// Grid fault qualifier top level: input register, limit registers, qualifier
// state and result word. Depends on gfq_pkg and gfq_eval.
// An accepted word waits in the input register until the result word is free, then updates the state.
// Throughput: one word per cycle while rsp_stall is low; state updates in one pass of gfq_eval.
// Reset: synchronous; counters, flags and last error clear, limits take
// their defaults (low limits 0, high limits 4095), no word is held.
module grid_fault_qualifier_top (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_stall,
   input  logic [1:0]                      req_mode,
   input  logic                            req_settled,
   input  logic [gfq_pkg::SAMPLE_BITS-1:0] req_volt_r,
   input  logic [gfq_pkg::SAMPLE_BITS-1:0] req_volt_y,
   input  logic [gfq_pkg::SAMPLE_BITS-1:0] req_volt_b,
   input  logic [gfq_pkg::SAMPLE_BITS-1:0] req_curr_r,
   input  logic [gfq_pkg::SAMPLE_BITS-1:0] req_curr_y,
   input  logic [gfq_pkg::SAMPLE_BITS-1:0] req_curr_b,
   input  logic [gfq_pkg::SAMPLE_BITS-1:0] req_grid_freq,
   output logic                            rsp_valid,
   input  logic                            rsp_stall,
   output logic                            rsp_undervolt_fault,
   output logic                            rsp_overvolt_fault,
   output logic                            rsp_freq_fault,
   output logic                            rsp_overcurrent_fault,
   output logic [2:0]                      rsp_last_error,
   input  logic                            csr_write_en,
   input  logic [gfq_pkg::CSR_IDX_BITS-1:0] csr_index,
   input  logic [gfq_pkg::SAMPLE_BITS-1:0] csr_wdata
);
   import gfq_pkg::*;

   logic           tick_valid_ff;
   logic           tick_valid_in;
   tick_type       tick_ff;
   logic           rsp_valid_ff;
   logic           rsp_valid_in;
   qual_state_type state_ff;
   qual_state_type state_in;
   limits_type     limits_ff;
   logic           req_take;
   logic           advance;

   assign advance       = tick_valid_ff && (!rsp_valid_ff || !rsp_stall);
   assign req_stall     = tick_valid_ff && !advance;
   assign req_take      = req_valid && !req_stall;
   assign tick_valid_in = req_take || (tick_valid_ff && !advance);
   assign rsp_valid_in  = advance || (rsp_valid_ff && rsp_stall);

   gfq_eval u_eval (
      .tick      (tick_ff),
      .limits    (limits_ff),
      .state_cur (state_ff),
      .state_nxt (state_in)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         tick_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
         state_ff      <= '{default: '0, err: ERR_NONE};
      end else begin
         tick_valid_ff <= tick_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
         if (advance) begin
            state_ff <= state_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         tick_ff.mode      <= mode_type'(req_mode);
         tick_ff.settled   <= req_settled;
         tick_ff.volt_r    <= req_volt_r;
         tick_ff.volt_y    <= req_volt_y;
         tick_ff.volt_b    <= req_volt_b;
         tick_ff.curr_r    <= req_curr_r;
         tick_ff.curr_y    <= req_curr_y;
         tick_ff.curr_b    <= req_curr_b;
         tick_ff.grid_freq <= req_grid_freq;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         limits_ff.undervolt   <= '0;
         limits_ff.overvolt    <= '1;
         limits_ff.freq_low    <= '0;
         limits_ff.freq_high   <= '1;
         limits_ff.overcurrent <= '1;
         limits_ff.measure     <= '1;
      end else if (csr_write_en) begin
         case (csr_index)
            CSR_UNDERVOLT: limits_ff.undervolt   <= csr_wdata;
            CSR_OVERVOLT:  limits_ff.overvolt    <= csr_wdata;
            CSR_FREQ_LOW:  limits_ff.freq_low    <= csr_wdata;
            CSR_FREQ_HIGH: limits_ff.freq_high   <= csr_wdata;
            CSR_OVERCURR:  limits_ff.overcurrent <= csr_wdata;
            CSR_MEASURE:   limits_ff.measure     <= csr_wdata;
            default: ;
         endcase
      end
   end

   // flags and error register hold while the result word is stalled
   assign rsp_valid             = rsp_valid_ff;
   assign rsp_undervolt_fault   = state_ff.uv_flag;
   assign rsp_overvolt_fault    = state_ff.ov_flag;
   assign rsp_freq_fault        = state_ff.fq_flag;
   assign rsp_overcurrent_fault = state_ff.oc_flag;
   assign rsp_last_error        = state_ff.err;

endmodule

### tb/tb_grid_fault_qualifier_top.sv
// Self-checking bench for grid_fault_qualifier_top: queued tick driver, result monitor and
// an in-bench fault qualifier that predicts each result word. Depends on gfq_pkg and the RTL.
module tb_grid_fault_qualifier_top;
   import gfq_pkg::*;

   localparam int PHASE_TICKS = 145;
   localparam int HOLD_AT = 250;
   localparam int LONG_HOLD = 300;
   localparam int CYCLE_LIMIT = 500000;

   typedef struct packed {
      logic    uv;
      logic    ov;
      logic    fq;
      logic    oc;
      err_type err;
   } fault_word_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_stall;
   logic [1:0] req_mode = '0;
   logic req_settled = 1'b0;
   sample_type req_volt_r = '0;
   sample_type req_volt_y = '0;
   sample_type req_volt_b = '0;
   sample_type req_curr_r = '0;
   sample_type req_curr_y = '0;
   sample_type req_curr_b = '0;
   sample_type req_grid_freq = '0;
   logic rsp_valid;
   logic rsp_stall = 1'b0;
   logic rsp_undervolt_fault;
   logic rsp_overvolt_fault;
   logic rsp_freq_fault;
   logic rsp_overcurrent_fault;
   logic [2:0] rsp_last_error;
   logic csr_write_en = 1'b0;
   logic [CSR_IDX_BITS-1:0] csr_index = '0;
   sample_type csr_wdata = '0;

   tick_type ticks_pending[$];
   fault_word_type fault_words_due[$];
   tick_type tick_on_bus;
   fault_word_type seen_word;
   fault_word_type want_word;

   limits_type lim;
   int uv_run, ov_run, fq_run;
   logic uv_flag, ov_flag, fq_flag, oc_flag;
   err_type last_err;

   int ticks_total = 0;
   int results_seen = 0;
   int mismatch_count = 0;
   int cycle_count = 0;
   int send_gap = 0;
   int stall_left = 0;
   bit burst_mode = 1'b0;
   bit long_hold_done = 1'b0;

   grid_fault_qualifier_top dut (.*);

   always #5 clock = ~clock;

   function automatic void persist(input logic hit, inout int count, input int cap,
                                   inout logic flag, input err_type code);
      if (hit) begin
         count++;
         if (count >= cap) begin
            count = 0;
            flag = 1'b1;
            last_err = code;
         end else begin
            flag = 1'b0;
         end
      end else begin
         count = 0;
         flag = 1'b0;
      end
   endfunction

   function automatic void trip_current(tick_type t, sample_type cap, err_type code);
      if (t.curr_r >= cap || t.curr_y >= cap || t.curr_b >= cap) begin
         oc_flag = 1'b1;
         last_err = code;
      end else begin
         oc_flag = 1'b0;
      end
   endfunction

   function automatic fault_word_type qualify_tick(tick_type t);
      fault_word_type w;
      logic uv_hit, ov_hit, fq_hit;
      uv_hit = t.volt_r <= lim.undervolt || t.volt_y <= lim.undervolt ||
               t.volt_b <= lim.undervolt;
      ov_hit = t.volt_r >= lim.overvolt || t.volt_y >= lim.overvolt ||
               t.volt_b >= lim.overvolt;
      fq_hit = t.grid_freq <= lim.freq_low || t.grid_freq >= lim.freq_high;
      case (t.mode)
         MODE_STARTUP: begin
            persist(uv_hit, uv_run, VOLT_LIMIT_STARTUP, uv_flag, ERR_VOLT_LOW);
            persist(ov_hit, ov_run, VOLT_LIMIT_STARTUP, ov_flag, ERR_VOLT_HIGH);
            persist(fq_hit, fq_run, FREQ_LIMIT, fq_flag, ERR_FREQ);
            trip_current(t, lim.measure, ERR_MEASURE);
         end
         MODE_RUNNING: if (t.settled) begin
            trip_current(t, lim.overcurrent, ERR_CURR_HIGH);
            persist(uv_hit, uv_run, VOLT_LIMIT_RUNNING, uv_flag, ERR_VOLT_LOW);
            persist(ov_hit, ov_run, VOLT_LIMIT_RUNNING, ov_flag, ERR_VOLT_HIGH);
            persist(fq_hit, fq_run, FREQ_LIMIT, fq_flag, ERR_FREQ);
         end
         MODE_RAMPUP: if (t.settled) begin
            trip_current(t, lim.overcurrent, ERR_CURR_HIGH);
         end
         default: ;
      endcase
      w.uv = uv_flag;
      w.ov = ov_flag;
      w.fq = fq_flag;
      w.oc = oc_flag;
      w.err = last_err;
      return w;
   endfunction

   function automatic int idle_cycles();
      int r;
      r = $urandom_range(0, 99);
      if (burst_mode || r < 55) return 0;
      if (r < 85) return $urandom_range(1, 3);
      if (r < 97) return $urandom_range(4, 10);
      return $urandom_range(20, 60);
   endfunction

   function automatic sample_type pick_between(int lo, int hi);
      if (lo > hi) return sample_type'($urandom);
      return sample_type'($urandom_range(hi, lo));
   endfunction

   function automatic tick_type any_tick();
      tick_type t;
      t.mode = mode_type'($urandom_range(0, 3));
      t.settled = 1'($urandom_range(0, 1));
      t.volt_r = sample_type'($urandom);
      t.volt_y = sample_type'($urandom);
      t.volt_b = sample_type'($urandom);
      t.curr_r = sample_type'($urandom);
      t.curr_y = sample_type'($urandom);
      t.curr_b = sample_type'($urandom);
      t.grid_freq = sample_type'($urandom);
      return t;
   endfunction

   function automatic tick_type shaped_tick(mode_type m, logic s, logic [3:0] faults);
      tick_type t;
      sample_type v[3];
      sample_type c[3];
      int cap;
      int k;
      cap = (m == MODE_STARTUP) ? int'(lim.measure) : int'(lim.overcurrent);
      for (k = 0; k < 3; k++) begin
         v[k] = pick_between(int'(lim.undervolt) + 1, int'(lim.overvolt) - 1);
         c[k] = pick_between(0, cap - 1);
      end
      if (faults[0]) v[$urandom_range(0, 2)] = pick_between(0, int'(lim.undervolt));
      if (faults[1]) v[$urandom_range(0, 2)] = pick_between(int'(lim.overvolt), 4095);
      if (faults[3]) c[$urandom_range(0, 2)] = pick_between(cap, 4095);
      if (!faults[2]) begin
         t.grid_freq = pick_between(int'(lim.freq_low) + 1, int'(lim.freq_high) - 1);
      end else if ($urandom_range(0, 1)) begin
         t.grid_freq = pick_between(0, int'(lim.freq_low));
      end else begin
         t.grid_freq = pick_between(int'(lim.freq_high), 4095);
      end
      t.mode = m;
      t.settled = s;
      t.volt_r = v[0];
      t.volt_y = v[1];
      t.volt_b = v[2];
      t.curr_r = c[0];
      t.curr_y = c[1];
      t.curr_b = c[2];
      return t;
   endfunction

   task automatic queue_tick(tick_type t);
      ticks_pending.push_back(t);
      ticks_total++;
   endtask

   task automatic queue_fixed(mode_type m, logic s, int vr, int vy, int vb,
                              int cr, int cy, int cb, int f);
      tick_type t;
      t.mode = m;
      t.settled = s;
      t.volt_r = sample_type'(vr);
      t.volt_y = sample_type'(vy);
      t.volt_b = sample_type'(vb);
      t.curr_r = sample_type'(cr);
      t.curr_y = sample_type'(cy);
      t.curr_b = sample_type'(cb);
      t.grid_freq = sample_type'(f);
      queue_tick(t);
   endtask

   task automatic write_reg(logic [CSR_IDX_BITS-1:0] idx, sample_type value);
      @(posedge clock);
      csr_write_en <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
   endtask

   task automatic load_limits(limits_type l);
      write_reg(CSR_UNDERVOLT, l.undervolt);
      write_reg(CSR_OVERVOLT, l.overvolt);
      write_reg(CSR_FREQ_LOW, l.freq_low);
      write_reg(CSR_FREQ_HIGH, l.freq_high);
      write_reg(CSR_OVERCURR, l.overcurrent);
      write_reg(CSR_MEASURE, l.measure);
      @(posedge clock);
      csr_write_en <= 1'b0;
      lim = l;
   endtask

   task automatic wait_drain();
      while (results_seen != ticks_total) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic queue_random_phase();
      tick_type t;
      mode_type m;
      logic s;
      logic [3:0] faults;
      int pushed;
      int run_len;
      int roll;
      int k;
      pushed = 0;
      while (pushed < PHASE_TICKS) begin
         run_len = $urandom_range(1, 24);
         roll = $urandom_range(0, 99);
         if (roll < 50) m = MODE_RUNNING;
         else if (roll < 75) m = MODE_STARTUP;
         else if (roll < 90) m = MODE_RAMPUP;
         else m = MODE_OTHER;
         s = ($urandom_range(0, 9) != 0);
         faults = 4'($urandom);
         for (k = 0; k < run_len; k++) begin
            if ($urandom_range(0, 9) == 0) t = any_tick();
            else t = shaped_tick(m, s, faults);
            if ($urandom_range(0, 19) == 0) faults[$urandom_range(0, 3)] ^= 1'b1;
            queue_tick(t);
            pushed++;
         end
      end
   endtask

   // driver
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
         send_gap = 0;
      end else begin
         if (req_valid && !req_stall) fault_words_due.push_back(qualify_tick(tick_on_bus));
         if (!req_valid || !req_stall) begin
            if (send_gap > 0) begin
               send_gap--;
               req_valid <= 1'b0;
            end else if (ticks_pending.size() > 0) begin
               tick_on_bus = ticks_pending.pop_front();
               req_mode <= tick_on_bus.mode;
               req_settled <= tick_on_bus.settled;
               req_volt_r <= tick_on_bus.volt_r;
               req_volt_y <= tick_on_bus.volt_y;
               req_volt_b <= tick_on_bus.volt_b;
               req_curr_r <= tick_on_bus.curr_r;
               req_curr_y <= tick_on_bus.curr_y;
               req_curr_b <= tick_on_bus.curr_b;
               req_grid_freq <= tick_on_bus.grid_freq;
               req_valid <= 1'b1;
               send_gap = idle_cycles();
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // monitor
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
         stall_left = 0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            seen_word.uv = rsp_undervolt_fault;
            seen_word.ov = rsp_overvolt_fault;
            seen_word.fq = rsp_freq_fault;
            seen_word.oc = rsp_overcurrent_fault;
            seen_word.err = err_type'(rsp_last_error);
            results_seen++;
            if (fault_words_due.size() == 0) begin
               mismatch_count++;
               if (mismatch_count <= 10)
                  $display("result word %0d arrived with nothing expected", results_seen);
            end else begin
               want_word = fault_words_due.pop_front();
               if (want_word !== seen_word) begin
                  mismatch_count++;
                  if (mismatch_count <= 10)
                     $display("word %0d: expected uv/ov/fq/oc=%b err=%0d, got %b err=%0d",
                              results_seen,
                              {want_word.uv, want_word.ov, want_word.fq, want_word.oc},
                              want_word.err,
                              {seen_word.uv, seen_word.ov, seen_word.fq, seen_word.oc},
                              seen_word.err);
               end
            end
         end
         if (!long_hold_done && results_seen >= HOLD_AT) begin
            long_hold_done = 1'b1;
            stall_left = LONG_HOLD;
         end
         if (stall_left > 0) begin
            stall_left--;
            rsp_stall <= 1'b1;
         end else begin
            rsp_stall <= 1'b0;
            if (!burst_mode && $urandom_range(0, 2) == 0) stall_left = idle_cycles();
         end
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("DONE: errors detected");
         $finish;
      end
   end

   initial begin
      limits_type l;
      int phase;
      uv_run = 0;
      ov_run = 0;
      fq_run = 0;
      uv_flag = 1'b0;
      ov_flag = 1'b0;
      fq_flag = 1'b0;
      oc_flag = 1'b0;
      last_err = ERR_NONE;
      lim = '{undervolt: 0, overvolt: 4095, freq_low: 0, freq_high: 4095,
              overcurrent: 4095, measure: 4095};
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      load_limits('{undervolt: 1000, overvolt: 3000, freq_low: 1000, freq_high: 3000,
                    overcurrent: 2000, measure: 3500});
      queue_fixed(MODE_STARTUP, 1'b1, 2000, 2000, 2000, 500, 500, 500, 2000);
      repeat (5) queue_fixed(MODE_STARTUP, 1'b1, 0, 4095, 2000, 4095, 500, 500, 4095);
      // hold undervoltage through nine running ticks, then drop to startup
      repeat (9) queue_fixed(MODE_RUNNING, 1'b1, 2000, 0, 2000, 500, 500, 500, 2000);
      queue_fixed(MODE_STARTUP, 1'b1, 2000, 0, 2000, 500, 500, 500, 2000);
      queue_fixed(MODE_RUNNING, 1'b1, 2000, 2000, 2000, 500, 500, 4095, 2000);
      queue_fixed(MODE_RAMPUP, 1'b1, 2000, 2000, 2000, 2000, 500, 500, 2000);
      queue_fixed(MODE_RAMPUP, 1'b0, 0, 0, 0, 4095, 4095, 4095, 0);
      queue_fixed(MODE_OTHER, 1'b1, 4095, 4095, 4095, 4095, 4095, 4095, 4095);
      queue_fixed(MODE_RUNNING, 1'b0, 0, 4095, 0, 4095, 4095, 4095, 4095);
      queue_fixed(MODE_RUNNING, 1'b1, 2000, 2000, 2000, 500, 500, 500, 2000);
      queue_fixed(MODE_STARTUP, 1'b0, 2000, 2000, 2000, 3500, 500, 500, 1000);
      wait_drain();

      for (phase = 0; phase < 4; phase++) begin
         case (phase)
            0: l = '{undervolt: sample_type'($urandom_range(200, 1500)),
                     overvolt: sample_type'($urandom_range(2500, 3900)),
                     freq_low: sample_type'($urandom_range(200, 1500)),
                     freq_high: sample_type'($urandom_range(2500, 3900)),
                     overcurrent: sample_type'($urandom_range(1000, 4000)),
                     measure: sample_type'($urandom_range(1000, 4000))};
            1: l = '{undervolt: 4095, overvolt: 0, freq_low: 4095, freq_high: 0,
                     overcurrent: 0, measure: 0};
            2: l = '{undervolt: 0, overvolt: 4095, freq_low: 0, freq_high: 4095,
                     overcurrent: 4095, measure: 4095};
            default: l = '{undervolt: sample_type'($urandom_range(0, 4095)),
                           overvolt: sample_type'($urandom_range(0, 4095)),
                           freq_low: sample_type'($urandom_range(0, 4095)),
                           freq_high: sample_type'($urandom_range(0, 4095)),
                           overcurrent: sample_type'($urandom_range(0, 4095)),
                           measure: sample_type'($urandom_range(0, 4095))};
         endcase
         load_limits(l);
         burst_mode = (phase == 2);
         queue_random_phase();
         wait_drain();
      end
      burst_mode = 1'b0;

      repeat (10) @(posedge clock);
      $display("Ran %0d ticks across 5 limit settings, all modes and settle states,",
               ticks_total);
      $display("with one %0d-cycle receiver hold and one gap-free phase; %0d mismatches.",
               LONG_HOLD, mismatch_count);
      if (mismatch_count == 0 && fault_words_due.size() == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

endmodule
